### hdl/tbgi_pkg.sv
// Shared constants, types and helpers of the tensor basis gradient interpolator.
package tbgi_pkg;

  localparam int MAX_DOFS_1D    = 8;
  localparam int MAX_QUADS_1D   = 8;
  localparam int MAX_COMPONENTS = 3;

  localparam int MAX_1D = (MAX_DOFS_1D > MAX_QUADS_1D) ? MAX_DOFS_1D : MAX_QUADS_1D;
  localparam int IDX_W  = $clog2(MAX_1D);
  localparam int LIM_W  = $clog2(MAX_1D + 1);
  localparam int NC_W   = $clog2(MAX_COMPONENTS + 1);
  localparam int CMP_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  localparam int TAB_SIZE = MAX_QUADS_1D * MAX_DOFS_1D;
  localparam int DOF_SIZE = MAX_DOFS_1D * MAX_DOFS_1D * MAX_DOFS_1D;
  localparam int S1_SIZE  = MAX_DOFS_1D * MAX_DOFS_1D * MAX_QUADS_1D;
  localparam int S2_SIZE  = MAX_DOFS_1D * MAX_QUADS_1D * MAX_QUADS_1D;
  localparam int RES_SIZE = MAX_COMPONENTS * MAX_QUADS_1D * MAX_QUADS_1D * MAX_QUADS_1D;

  localparam int TAB_AW = $clog2(TAB_SIZE);
  localparam int DOF_AW = $clog2(DOF_SIZE);
  localparam int S1_AW  = $clog2(S1_SIZE);
  localparam int S2_AW  = $clog2(S2_SIZE);
  localparam int RES_AW = $clog2(RES_SIZE);

  localparam int DATA_W     = 32;
  localparam int COEF_W     = 32;
  localparam int VAL_W      = 48;
  localparam int FRAC_SHIFT = 24;
  localparam int ACC_W      = VAL_W + COEF_W + $clog2(MAX_DOFS_1D) + 1;
  localparam int CYC_W      = $clog2(2 * MAX_DOFS_1D + 3);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DOF    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_DIMENSION      = 2'd0;
  localparam logic [1:0] CFG_NUM_COMPONENTS = 2'd1;
  localparam logic [1:0] CFG_DOFS_1D        = 2'd2;
  localparam logic [1:0] CFG_QUADS_1D       = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_OUT_RD,
    ST_OUT_SEND
  } state_t;

  typedef enum logic [1:0] {
    PASS_ONE,
    PASS_TWO,
    PASS_THREE
  } pass_t;

  typedef struct packed {
    logic clear;
    logic op_valid;
  } mac_ctrl_t;

  function automatic int clamp_cfg(input int v, input int hi);
    int t;
    t = v;
    if (t == 0) t = 1;
    if (t > hi) t = hi;
    return t;
  endfunction

endpackage

### hdl/tbgi_mac.sv
// Multiply-accumulate lane: two partial products per term, round and saturate.
module tbgi_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  tbgi_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [tbgi_pkg::VAL_W-1:0]   a,
  input  logic signed [tbgi_pkg::COEF_W-1:0]  b,
  output logic signed [tbgi_pkg::VAL_W-1:0]   result
);
  import tbgi_pkg::*;

  localparam int LO_W   = VAL_W / 2;
  localparam int HI_W   = VAL_W - LO_W;
  localparam int PROD_W = LO_W + 1 + COEF_W;
  localparam int SH_W   = ACC_W - FRAC_SHIFT;

  logic signed [HI_W-1:0]   a_hi;
  logic signed [COEF_W-1:0] b_hold;
  logic                     hi_pend;
  logic                     prod_v;
  logic                     prod_hi;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p_lo;
  logic signed [PROD_W-1:0] p_hi;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shifted;
  logic                     fits;

  assign p_lo = PROD_W'($signed({1'b0, a[LO_W-1:0]}) * b);
  assign p_hi = PROD_W'(a_hi * b_hold);

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_pend <= 1'b0;
      prod_v  <= 1'b0;
    end else begin
      hi_pend <= ctrl.op_valid;
      prod_v  <= ctrl.op_valid | hi_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op_valid) begin
      prod    <= p_lo;
      prod_hi <= 1'b0;
      a_hi    <= a[VAL_W-1:LO_W];
      b_hold  <= b;
    end else if (hi_pend) begin
      prod    <= p_hi;
      prod_hi <= 1'b1;
    end
  end

  assign addend = prod_hi ? (ACC_W'(prod) <<< LO_W) : ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + addend;
    end
  end

  assign rnd     = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
  assign shifted = $signed(rnd[ACC_W-1:FRAC_SHIFT]);
  assign fits    = (&shifted[SH_W-1:VAL_W-1]) | ~(|shifted[SH_W-1:VAL_W-1]);

  always_comb begin
    if (fits) begin
      result = shifted[VAL_W-1:0];
    end else if (shifted[SH_W-1]) begin
      result = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

### hdl/tensor_basis_gradient_interpolator.sv
// Top level: tables, stage memories, pass sequencer and row readout.
//
// One input channel (in_valid/in_stall) carries three transaction kinds: a
// basis table load, a dof value, or a row read. Config writes (cfg_we) only
// while idle; each also restarts the dof and component counters.
// Loads and dof values are taken back to back while idle. The last dof value of a component
// starts the sum-factorized passes, during which in_stall stays high.
// Each computed point runs over D terms: every lane multiplier forms two
// partial products per term. Points per component: D*D*Q + D*Q*Q + Q*Q*Q
// in 3D, D*Q + Q*Q in 2D.
// A row read returns Q results on out_valid/out_stall; each is fetched from
// the result memory in ST_OUT_RD and then shown in ST_OUT_SEND.
// A stalled result holds, and no input is taken until the row is out.
// Reset sets dimension 2, one component, D = Q = 4 and clears the counters.
// Table, dof and result memories hold nothing defined until written.
module tensor_basis_gradient_interpolator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [2:0]          quad_index,
  input  logic [2:0]          dof_index,
  input  logic signed [31:0]  basis_value,
  input  logic signed [31:0]  gradient_basis_value,
  input  logic signed [31:0]  dof_value,
  input  logic [2:0]          row_y,
  input  logic [2:0]          row_z,
  input  logic [1:0]          component,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          quad_x,
  output logic signed [47:0]  derivative_x,
  output logic signed [47:0]  derivative_y,
  output logic signed [47:0]  derivative_z,
  output logic                last_in_row
);
  import tbgi_pkg::*;

  logic [1:0] dimension;
  logic [1:0] num_components;
  logic [3:0] dofs_1d;
  logic [3:0] quads_1d;

  logic             three;
  logic [LIM_W-1:0] d_lim;
  logic [LIM_W-1:0] q_lim;
  logic [NC_W-1:0]  nc_lim;

  state_t            state;
  state_t            state_next;
  pass_t             pass;
  logic [IDX_W-1:0]  o0;
  logic [IDX_W-1:0]  o1;
  logic [IDX_W-1:0]  o2;
  logic [IDX_W-1:0]  ry;
  logic [IDX_W-1:0]  rz;
  logic [IDX_W-1:0]  qx;
  logic [CMP_W-1:0]  pc;
  logic [CMP_W-1:0]  rc;
  logic [CMP_W-1:0]  component_counter;
  logic [DOF_AW-1:0] dof_counter;
  logic [CYC_W-1:0]  cyc;
  logic              op_v;

  cmd_t              cmd;
  logic              in_acc;
  logic              out_acc;
  logic              last_dof;
  logic              issue;
  logic              wr_point;
  logic              last_point;
  logic              pass_end;
  logic              row_last;
  logic [CYC_W-2:0]  term;
  logic [IDX_W-1:0]  ti;
  logic [LIM_W-1:0]  lim0;
  logic [LIM_W-1:0]  lim1;
  logic [LIM_W-1:0]  lim2;

  logic              tab_we;
  logic              dof_we;
  logic              s1_we;
  logic              s2_we;
  logic              res_we;
  logic              res_re;
  logic [TAB_AW-1:0] tab_wa;
  logic [TAB_AW-1:0] coef_ra;
  logic [DOF_AW-1:0] dof_ra;
  logic [S1_AW-1:0]  s1_ra;
  logic [S1_AW-1:0]  s1_wa;
  logic [S2_AW-1:0]  s2_ra;
  logic [S2_AW-1:0]  s2_wa;
  logic [RES_AW-1:0] res_ra;
  logic [RES_AW-1:0] res_wa;
  logic [IDX_W-1:0]  res_z;

  logic signed [COEF_W-1:0] basis_mem [TAB_SIZE];
  logic signed [COEF_W-1:0] grad_mem  [TAB_SIZE];
  logic signed [DATA_W-1:0] dof_mem   [DOF_SIZE];
  logic signed [VAL_W-1:0]  s1i_mem   [S1_SIZE];
  logic signed [VAL_W-1:0]  s1d_mem   [S1_SIZE];
  logic signed [VAL_W-1:0]  s2x_mem   [S2_SIZE];
  logic signed [VAL_W-1:0]  s2y_mem   [S2_SIZE];
  logic signed [VAL_W-1:0]  s2z_mem   [S2_SIZE];
  logic signed [VAL_W-1:0]  resx_mem  [RES_SIZE];
  logic signed [VAL_W-1:0]  resy_mem  [RES_SIZE];
  logic signed [VAL_W-1:0]  resz_mem  [RES_SIZE];

  logic signed [COEF_W-1:0] basis_rd;
  logic signed [COEF_W-1:0] grad_rd;
  logic signed [DATA_W-1:0] dof_rd;
  logic signed [VAL_W-1:0]  s1i_rd;
  logic signed [VAL_W-1:0]  s1d_rd;
  logic signed [VAL_W-1:0]  s2x_rd;
  logic signed [VAL_W-1:0]  s2y_rd;
  logic signed [VAL_W-1:0]  s2z_rd;
  logic signed [VAL_W-1:0]  resx_rd;
  logic signed [VAL_W-1:0]  resy_rd;
  logic signed [VAL_W-1:0]  resz_rd;

  logic signed [VAL_W-1:0]  dof_ext;
  logic signed [VAL_W-1:0]  a0, a1, a2;
  logic signed [COEF_W-1:0] b0, b1, b2;
  logic signed [VAL_W-1:0]  r0, r1, r2;
  mac_ctrl_t                mctrl;

  // configuration decode
  assign three  = (dimension == 2'd3);
  assign d_lim  = LIM_W'(clamp_cfg(int'(dofs_1d), MAX_DOFS_1D));
  assign q_lim  = LIM_W'(clamp_cfg(int'(quads_1d), MAX_QUADS_1D));
  assign nc_lim = NC_W'(clamp_cfg(int'(num_components), MAX_COMPONENTS));

  assign cmd     = cmd_t'(command);
  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  assign last_dof = (int'(dof_counter) + 1) >=
                    (three ? int'(d_lim) * int'(d_lim) * int'(d_lim)
                           : int'(d_lim) * int'(d_lim));

  // loop bounds of the current pass
  assign lim0 = q_lim;
  assign lim1 = (pass == PASS_ONE) ? d_lim : q_lim;
  assign lim2 = (pass == PASS_THREE) ? q_lim : (three ? d_lim : LIM_W'(1));

  assign term     = cyc[CYC_W-1:1];
  assign ti       = term[IDX_W-1:0];
  assign issue    = (state == ST_PASS) && !cyc[0] && (int'(term) < int'(d_lim));
  assign wr_point = (state == ST_PASS) && (int'(cyc) == 2 * int'(d_lim) + 2);

  assign last_point = (int'(o0) + 1 >= int'(lim0)) && (int'(o1) + 1 >= int'(lim1)) &&
                      (int'(o2) + 1 >= int'(lim2));
  assign pass_end   = wr_point && last_point &&
                      ((pass == PASS_THREE) || ((pass == PASS_TWO) && !three));
  assign row_last   = (int'(qx) + 1 == int'(q_lim));

  // addresses
  assign tab_wa = TAB_AW'(int'(quad_index) * MAX_DOFS_1D + int'(dof_index));
  assign tab_we = in_acc && (cmd == CMD_LOAD) &&
                  (int'(quad_index) < MAX_QUADS_1D) && (int'(dof_index) < MAX_DOFS_1D);
  assign dof_we = in_acc && (cmd == CMD_DOF);

  always_comb begin
    case (pass)
      PASS_TWO:   coef_ra = TAB_AW'(int'(o1) * MAX_DOFS_1D + int'(ti));
      PASS_THREE: coef_ra = TAB_AW'(int'(o2) * MAX_DOFS_1D + int'(ti));
      default:    coef_ra = TAB_AW'(int'(o0) * MAX_DOFS_1D + int'(ti));
    endcase
  end

  assign dof_ra = DOF_AW'(int'(d_lim) * (int'(o1) + int'(d_lim) * int'(o2)) + int'(ti));
  assign s1_ra  = S1_AW'((int'(o2) * MAX_DOFS_1D + int'(ti)) * MAX_QUADS_1D + int'(o0));
  assign s2_ra  = S2_AW'((int'(ti) * MAX_QUADS_1D + int'(o1)) * MAX_QUADS_1D + int'(o0));
  assign s1_wa  = S1_AW'((int'(o2) * MAX_DOFS_1D + int'(o1)) * MAX_QUADS_1D + int'(o0));
  assign s2_wa  = S2_AW'((int'(o2) * MAX_QUADS_1D + int'(o1)) * MAX_QUADS_1D + int'(o0));
  assign res_z  = (pass == PASS_THREE) ? o2 : '0;
  assign res_wa = RES_AW'(((int'(pc) * MAX_QUADS_1D + int'(res_z)) * MAX_QUADS_1D
                           + int'(o1)) * MAX_QUADS_1D + int'(o0));
  assign res_ra = RES_AW'(((int'(rc) * MAX_QUADS_1D + int'(rz)) * MAX_QUADS_1D
                           + int'(ry)) * MAX_QUADS_1D + int'(qx));

  assign s1_we  = wr_point && (pass == PASS_ONE);
  assign s2_we  = wr_point && (pass == PASS_TWO) && three;
  assign res_we = wr_point && (((pass == PASS_TWO) && !three) || (pass == PASS_THREE));
  assign res_re = (state == ST_OUT_RD);

  // memories
  always_ff @(posedge clk) begin
    if (tab_we) begin
      basis_mem[tab_wa] <= basis_value;
      grad_mem[tab_wa]  <= gradient_basis_value;
    end
    basis_rd <= basis_mem[coef_ra];
    grad_rd  <= grad_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (dof_we) dof_mem[dof_counter] <= dof_value;
    dof_rd <= dof_mem[dof_ra];
  end

  always_ff @(posedge clk) begin
    if (s1_we) begin
      s1i_mem[s1_wa] <= r0;
      s1d_mem[s1_wa] <= r1;
    end
    s1i_rd <= s1i_mem[s1_ra];
    s1d_rd <= s1d_mem[s1_ra];
  end

  always_ff @(posedge clk) begin
    if (s2_we) begin
      s2x_mem[s2_wa] <= r0;
      s2y_mem[s2_wa] <= r1;
      s2z_mem[s2_wa] <= r2;
    end
    s2x_rd <= s2x_mem[s2_ra];
    s2y_rd <= s2y_mem[s2_ra];
    s2z_rd <= s2z_mem[s2_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      resx_mem[res_wa] <= r0;
      resy_mem[res_wa] <= r1;
      resz_mem[res_wa] <= (pass == PASS_THREE) ? r2 : '0;
    end
    if (res_re) begin
      resx_rd <= resx_mem[res_ra];
      resy_rd <= resy_mem[res_ra];
      resz_rd <= resz_mem[res_ra];
    end
  end

  // lane operands
  assign dof_ext = VAL_W'(dof_rd);

  always_comb begin
    case (pass)
      PASS_TWO: begin
        a0 = s1d_rd; b0 = basis_rd;
        a1 = s1i_rd; b1 = grad_rd;
        a2 = s1i_rd; b2 = basis_rd;
      end
      PASS_THREE: begin
        a0 = s2x_rd; b0 = basis_rd;
        a1 = s2y_rd; b1 = basis_rd;
        a2 = s2z_rd; b2 = grad_rd;
      end
      default: begin
        a0 = dof_ext; b0 = basis_rd;
        a1 = dof_ext; b1 = grad_rd;
        a2 = dof_ext; b2 = basis_rd;
      end
    endcase
  end

  assign mctrl.clear    = (state == ST_IDLE) || wr_point;
  assign mctrl.op_valid = op_v;

  tbgi_mac u_mac0 (.clk(clk), .rst(rst), .ctrl(mctrl), .a(a0), .b(b0), .result(r0));
  tbgi_mac u_mac1 (.clk(clk), .rst(rst), .ctrl(mctrl), .a(a1), .b(b1), .result(r1));
  tbgi_mac u_mac2 (.clk(clk), .rst(rst), .ctrl(mctrl), .a(a2), .b(b2), .result(r2));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (cmd == CMD_DOF) && last_dof) state_next = ST_PASS;
        else if (in_acc && (cmd == CMD_READ))       state_next = ST_OUT_RD;
      end
      ST_PASS: begin
        if (pass_end) state_next = ST_IDLE;
      end
      ST_OUT_RD: state_next = ST_OUT_SEND;
      ST_OUT_SEND: begin
        if (out_acc) state_next = row_last ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT_SEND);
  end

  assign quad_x       = 3'(qx);
  assign last_in_row  = row_last;
  assign derivative_x = resx_rd;
  assign derivative_y = resy_rd;
  assign derivative_z = three ? resz_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      dimension         <= 2'd2;
      num_components    <= 2'd1;
      dofs_1d           <= 4'd4;
      quads_1d          <= 4'd4;
      dof_counter       <= '0;
      component_counter <= '0;
      pass              <= PASS_ONE;
      o0                <= '0;
      o1                <= '0;
      o2                <= '0;
      cyc               <= '0;
      op_v              <= 1'b0;
      pc                <= '0;
      qx                <= '0;
    end else begin
      state <= state_next;
      op_v  <= issue;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIMENSION:      dimension      <= cfg_data[1:0];
          CFG_NUM_COMPONENTS: num_components <= cfg_data[1:0];
          CFG_DOFS_1D:        dofs_1d        <= cfg_data;
          CFG_QUADS_1D:       quads_1d       <= cfg_data;
          default:            dimension      <= dimension;
        endcase
        dof_counter       <= '0;
        component_counter <= '0;
      end else if (dof_we) begin
        if (last_dof) begin
          dof_counter <= '0;
          pc <= (int'(component_counter) < int'(nc_lim))
                ? component_counter : CMP_W'(int'(nc_lim) - 1);
          component_counter <= (int'(component_counter) + 1 >= int'(nc_lim))
                               ? '0 : CMP_W'(int'(component_counter) + 1);
          pass <= PASS_ONE;
          o0   <= '0;
          o1   <= '0;
          o2   <= '0;
          cyc  <= '0;
        end else begin
          dof_counter <= dof_counter + DOF_AW'(1);
        end
      end

      if (state == ST_PASS) begin
        cyc <= wr_point ? '0 : cyc + CYC_W'(1);
        if (wr_point) begin
          if (int'(o0) + 1 < int'(lim0)) begin
            o0 <= o0 + IDX_W'(1);
          end else begin
            o0 <= '0;
            if (int'(o1) + 1 < int'(lim1)) begin
              o1 <= o1 + IDX_W'(1);
            end else begin
              o1 <= '0;
              if (int'(o2) + 1 < int'(lim2)) begin
                o2 <= o2 + IDX_W'(1);
              end else begin
                o2 <= '0;
                if (pass == PASS_ONE) pass <= PASS_TWO;
                else if (pass == PASS_TWO) pass <= PASS_THREE;
              end
            end
          end
        end
      end

      if (in_acc && (cmd == CMD_READ)) qx <= '0;
      else if (out_acc) qx <= qx + IDX_W'(1);
    end
  end

  // read request, held for the whole row
  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_READ)) begin
      ry <= (int'(row_y) >= int'(q_lim)) ? IDX_W'(int'(q_lim) - 1) : IDX_W'(row_y);
      if (!three) rz <= '0;
      else rz <= (int'(row_z) >= int'(q_lim)) ? IDX_W'(int'(q_lim) - 1) : IDX_W'(row_z);
      rc <= (int'(component) >= int'(nc_lim)) ? CMP_W'(int'(nc_lim) - 1)
                                               : CMP_W'(component);
    end
  end

  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == CMD_READ) |=> ##1 out_valid)
    else $error("first result of a row read is late");

  a_row_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_in_row) |=> !out_valid)
    else $error("result shown after the last point of a row");

  a_pass_write_in_pass: assert property (@(posedge clk) disable iff (rst)
    (s1_we || s2_we || res_we) |-> ((state == ST_PASS) && !op_v))
    else $error("stage write outside a point boundary");

endmodule

### tb/tensor_basis_gradient_interpolator_tb.sv
// Self-checking testbench for the tensor basis gradient interpolator.
`timescale 1ns / 1ps
module tensor_basis_gradient_interpolator_tb;
  import tbgi_pkg::*;

  localparam int  CYCLE_LIMIT = 3000000;
  localparam longint SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_MIN = 64'shFFFF_8000_0000_0000;

  typedef struct {
    logic [2:0]  qx;
    logic [47:0] dx;
    logic [47:0] dy;
    logic [47:0] dz;
    logic        last;
  } row_point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic [2:0]  quad_index = '0;
  logic [2:0]  dof_index = '0;
  logic signed [31:0] basis_value = '0;
  logic signed [31:0] gradient_basis_value = '0;
  logic signed [31:0] dof_value = '0;
  logic [2:0]  row_y = '0;
  logic [2:0]  row_z = '0;
  logic [1:0]  component = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  quad_x;
  logic signed [47:0] derivative_x;
  logic signed [47:0] derivative_y;
  logic signed [47:0] derivative_z;
  logic        last_in_row;

  tensor_basis_gradient_interpolator u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of block state
  logic [1:0] dim_reg, nc_reg;
  logic [3:0] dofs_reg, quads_reg;
  longint btab [64];
  longint gtab [64];
  longint dof_mem [512];
  longint s1_interp [512];
  longint s1_deriv [512];
  longint s2_dx [512];
  longint s2_dy [512];
  longint s2_dz [512];
  longint grad_x [1536];
  longint grad_y [1536];
  longint grad_z [1536];
  int unsigned dof_count, comp_count;
  bit comp_ready [3];

  row_point_t expected_points [$];
  int errors = 0;
  int cycles = 0;
  bit idle_en = 1'b1;
  int sent_items = 0;

  function automatic int clampv(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int eff_d();
    return clampv(dofs_reg, MAX_DOFS_1D);
  endfunction

  function automatic int eff_q();
    return clampv(quads_reg, MAX_QUADS_1D);
  endfunction

  function automatic int eff_nc();
    return clampv(nc_reg, MAX_COMPONENTS);
  endfunction

  function automatic bit is_3d();
    return dim_reg == 2'd3;
  endfunction

  function automatic logic signed [127:0] mul(longint a, longint b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic longint round_sat(logic signed [127:0] acc);
    logic signed [127:0] r;
    r = (acc + 128'sd8388608) >>> 24;
    if (r > SAT_MAX) return SAT_MAX;
    if (r < SAT_MIN) return SAT_MIN;
    return longint'(r);
  endfunction

  function automatic void contract(int c);
    int d, q, nz, base, t;
    logic signed [127:0] a1, a2, a3;
    d = eff_d();
    q = eff_q();
    nz = is_3d() ? d : 1;
    for (int dz = 0; dz < nz; dz++)
      for (int dy = 0; dy < d; dy++)
        for (int qx = 0; qx < q; qx++) begin
          a1 = 0;
          a2 = 0;
          for (int i = 0; i < d; i++) begin
            a1 += mul(dof_mem[d * (dy + d * dz) + i], btab[qx * 8 + i]);
            a2 += mul(dof_mem[d * (dy + d * dz) + i], gtab[qx * 8 + i]);
          end
          s1_interp[(dz * 8 + dy) * 8 + qx] = round_sat(a1);
          s1_deriv[(dz * 8 + dy) * 8 + qx] = round_sat(a2);
        end
    if (!is_3d()) begin
      for (int qy = 0; qy < q; qy++)
        for (int qx = 0; qx < q; qx++) begin
          a1 = 0;
          a2 = 0;
          for (int i = 0; i < d; i++) begin
            a1 += mul(s1_deriv[qx + i * 8], btab[qy * 8 + i]);
            a2 += mul(s1_interp[qx + i * 8], gtab[qy * 8 + i]);
          end
          t = ((c * 8) * 8 + qy) * 8 + qx;
          grad_x[t] = round_sat(a1);
          grad_y[t] = round_sat(a2);
          grad_z[t] = 0;
        end
      return;
    end
    for (int dz = 0; dz < d; dz++)
      for (int qy = 0; qy < q; qy++)
        for (int qx = 0; qx < q; qx++) begin
          base = dz * 64 + qx;
          a1 = 0;
          a2 = 0;
          a3 = 0;
          for (int i = 0; i < d; i++) begin
            a1 += mul(s1_deriv[base + i * 8], btab[qy * 8 + i]);
            a2 += mul(s1_interp[base + i * 8], gtab[qy * 8 + i]);
            a3 += mul(s1_interp[base + i * 8], btab[qy * 8 + i]);
          end
          t = (dz * 8 + qy) * 8 + qx;
          s2_dx[t] = round_sat(a1);
          s2_dy[t] = round_sat(a2);
          s2_dz[t] = round_sat(a3);
        end
    for (int qz = 0; qz < q; qz++)
      for (int qy = 0; qy < q; qy++)
        for (int qx = 0; qx < q; qx++) begin
          base = qy * 8 + qx;
          a1 = 0;
          a2 = 0;
          a3 = 0;
          for (int i = 0; i < d; i++) begin
            a1 += mul(s2_dx[base + i * 64], btab[qz * 8 + i]);
            a2 += mul(s2_dy[base + i * 64], btab[qz * 8 + i]);
            a3 += mul(s2_dz[base + i * 64], gtab[qz * 8 + i]);
          end
          t = ((c * 8 + qz) * 8 + qy) * 8 + qx;
          grad_x[t] = round_sat(a1);
          grad_y[t] = round_sat(a2);
          grad_z[t] = round_sat(a3);
        end
  endfunction

  function automatic void predict(cmd_t cmd, logic [2:0] qi, logic [2:0] di,
                                  logic signed [31:0] bv, logic signed [31:0] gv,
                                  logic signed [31:0] dv, logic [2:0] ry,
                                  logic [2:0] rz, logic [1:0] comp);
    int q, nc, size, c, y, z, t;
    row_point_t p;
    q = eff_q();
    nc = eff_nc();
    size = is_3d() ? eff_d() ** 3 : eff_d() ** 2;
    case (cmd)
      CMD_LOAD: begin
        btab[qi * 8 + di] = longint'(bv);
        gtab[qi * 8 + di] = longint'(gv);
      end
      CMD_DOF: begin
        dof_mem[dof_count] = longint'(dv);
        if (dof_count + 1 >= size) begin
          c = (comp_count < nc) ? comp_count : nc - 1;
          contract(c);
          comp_ready[c] = 1'b1;
          dof_count = 0;
          comp_count = (comp_count + 1 >= nc) ? 0 : comp_count + 1;
        end else begin
          dof_count++;
        end
      end
      CMD_READ: begin
        y = (ry >= q) ? q - 1 : ry;
        z = !is_3d() ? 0 : ((rz >= q) ? q - 1 : rz);
        c = (comp >= nc) ? nc - 1 : comp;
        for (int qx = 0; qx < q; qx++) begin
          t = ((c * 8 + z) * 8 + y) * 8 + qx;
          p.qx = 3'(qx);
          p.dx = grad_x[t][47:0];
          p.dy = grad_y[t][47:0];
          p.dz = is_3d() ? grad_z[t][47:0] : 48'd0;
          p.last = (qx + 1 == q);
          expected_points.push_back(p);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pass_cycles();
    int d, q;
    d = eff_d();
    q = eff_q();
    if (is_3d()) return (d * d * q + d * q * q + q * q * q) * (2 * d + 3);
    return (d * q + q * q) * (2 * d + 3);
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dof();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic [2:0] qi, logic [2:0] di,
                           logic signed [31:0] bv, logic signed [31:0] gv,
                           logic signed [31:0] dv, logic [2:0] ry,
                           logic [2:0] rz, logic [1:0] comp);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    command = cmd;
    quad_index = qi;
    dof_index = di;
    basis_value = bv;
    gradient_basis_value = gv;
    dof_value = dv;
    row_y = ry;
    row_z = rz;
    component = comp;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict(cmd, qi, di, bv, gv, dv, ry, rz, comp);
  endtask

  task automatic load_entry(logic [2:0] qi, logic [2:0] di,
                            logic signed [31:0] bv, logic signed [31:0] gv);
    send_item(CMD_LOAD, qi, di, bv, gv, $urandom(), 3'($urandom()), 3'($urandom()),
              2'($urandom()));
  endtask

  task automatic push_dof(logic signed [31:0] dv);
    send_item(CMD_DOF, 3'($urandom()), 3'($urandom()), $urandom(), $urandom(), dv,
              3'($urandom()), 3'($urandom()), 2'($urandom()));
    sent_items++;
  endtask

  task automatic read_row(logic [2:0] ry, logic [2:0] rz, logic [1:0] comp);
    send_item(CMD_READ, 3'($urandom()), 3'($urandom()), $urandom(), $urandom(),
              $urandom(), ry, rz, comp);
    sent_items++;
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1))
      send_item(CMD_IGNORE, 3'($urandom()), 3'($urandom()), $urandom(), $urandom(),
                $urandom(), 3'($urandom()), 3'($urandom()), 2'($urandom()));
    else
      load_entry(3'($urandom()), 3'($urandom()), rand_coef(), rand_coef());
  endtask

  // read a row of some finished component, if any
  task automatic read_random();
    int c, nc;
    bit any;
    nc = eff_nc();
    any = 1'b0;
    for (int i = 0; i < 3; i++) any |= comp_ready[i];
    if (!any) return;
    do c = $urandom_range(0, nc - 1); while (!comp_ready[c]);
    read_row(3'($urandom()), 3'($urandom()),
             (c == nc - 1) ? 2'($urandom_range(c, 3)) : 2'(c));
  endtask

  task automatic stream_component(int noise_pct);
    int size;
    size = is_3d() ? eff_d() ** 3 : eff_d() ** 2;
    for (int i = 0; i < size; i++) begin
      while ($urandom_range(0, 99) < noise_pct) send_noise();
      push_dof(rand_dof());
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (pass_cycles() + 40) @(posedge clk);
  endtask

  task automatic set_config(logic [3:0] dim, logic [3:0] nc, logic [3:0] d, logic [3:0] q);
    logic [3:0] vals [4];
    vals = '{dim, nc, d, q};
    drain();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = i[1:0];
      cfg_data = vals[i];
      @(posedge clk);
      case (i[1:0])
        CFG_DIMENSION:      dim_reg = vals[i][1:0];
        CFG_NUM_COMPONENTS: nc_reg = vals[i][1:0];
        CFG_DOFS_1D:        dofs_reg = vals[i];
        default:            quads_reg = vals[i];
      endcase
      dof_count = 0;
      comp_count = 0;
      comp_ready = '{default: 1'b0};
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_element(int noise_pct, int reads);
    for (int c = 0; c < eff_nc(); c++) stream_component(noise_pct);
    repeat (reads) read_random();
  endtask

  // columns 0..3 of every row, and all of row 0 for eight dofs at one point
  task automatic test_table_load();
    for (int q = 0; q < MAX_QUADS_1D; q++)
      for (int d = 0; d < 4; d++)
        load_entry(3'(q), 3'(d), rand_coef(), rand_coef());
    for (int d = 4; d < MAX_DOFS_1D; d++)
      load_entry(3'd0, 3'(d), rand_coef(), rand_coef());
    load_entry(3'd7, 3'd3, 32'sh8000_0000, 32'sh7FFF_FFFF);
    load_entry(3'd0, 3'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(CMD_IGNORE, 3'd7, 3'd7, '1, '1, '1, 3'd7, 3'd7, 2'd3);
  endtask

  // reset settings: 2D, one component, D = Q = 4
  task automatic test_reset_defaults();
    push_dof(32'sh7FFF_FFFF);
    push_dof(32'sh8000_0000);
    push_dof(32'sh0);
    for (int i = 0; i < 13; i++) push_dof(rand_dof());
    read_row(3'd0, 3'd0, 2'd0);
    read_row(3'd3, 3'd5, 2'd0);
    read_row(3'd7, 3'd7, 2'd3);
    read_row(3'd1, 3'd0, 2'd2);
  endtask

  task automatic test_config_extremes();
    set_config(4'd0, 4'd0, 4'd0, 4'd0);
    run_element(0, 2);
    set_config(4'd1, 4'd3, 4'd2, 4'd8);
    run_element(5, 4);
    set_config(4'd3, 4'd1, 4'd1, 4'd8);
    run_element(0, 3);
    set_config(4'd2, 4'd1, 4'd15, 4'd1);
    run_element(5, 2);
    set_config(4'd7, 4'd15, 4'd1, 4'd15);
    run_element(5, 3);
  endtask

  task automatic test_partial_element();
    set_config(4'd3, 4'd3, 4'd2, 4'd3);
    stream_component(10);
    read_random();
    push_dof(rand_dof());
    push_dof(rand_dof());
    set_config(4'd2, 4'd1, 4'd3, 4'd2);
    run_element(10, 2);
  endtask

  task automatic test_random();
    int start;
    start = sent_items;
    while (sent_items - start < 20) begin
      idle_en = ($urandom_range(0, 3) != 0);
      set_config(4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                 4'($urandom_range(0, 3)),
                 ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8)));
      if ($urandom_range(0, 9) == 0) begin
        stream_component(20);
        repeat ($urandom_range(0, 5)) push_dof(rand_dof());
      end else begin
        run_element(15, $urandom_range(3, 8));
      end
    end
    idle_en = 1'b1;
  endtask

  always @(negedge clk) begin : out_stall_gen
    int left;
    if (left > 0) begin
      out_stall = 1'b1;
      left--;
    end else begin
      out_stall = 1'b0;
      if (idle_en && $urandom_range(0, 99) < 25)
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin : result_check
    row_point_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: quad_x=%0d", quad_x);
      end else begin
        e = expected_points.pop_front();
        if (quad_x !== e.qx || derivative_x !== e.dx || derivative_y !== e.dy ||
            derivative_z !== e.dz || last_in_row !== e.last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp qx=%0d dx=%h dy=%h dz=%h last=%b",
                      " got qx=%0d dx=%h dy=%h dz=%h last=%b"},
                     e.qx, e.dx, e.dy, e.dz, e.last, quad_x, derivative_x, derivative_y,
                     derivative_z, last_in_row);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tensor_basis_gradient_interpolator_tb NOT OK");
      $finish;
    end
  end

  initial begin
    dim_reg = 2'd2;
    nc_reg = 2'd1;
    dofs_reg = 4'd4;
    quads_reg = 4'd4;
    dof_count = 0;
    comp_count = 0;
    comp_ready = '{default: 1'b0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_table_load();
    test_reset_defaults();
    test_config_extremes();
    test_partial_element();
    test_random();
    drain();
    if (errors == 0)
      $display("tensor_basis_gradient_interpolator_tb OK");
    else
      $display("tensor_basis_gradient_interpolator_tb NOT OK");
    $finish;
  end

endmodule

### sim.f
hdl/tbgi_pkg.sv
hdl/tbgi_mac.sv
hdl/tensor_basis_gradient_interpolator.sv
tb/tensor_basis_gradient_interpolator_tb.sv
